[rtl/assert_macros.svh]
// Assertion macros shared by the counting multiset table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("property violated");
// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

[rtl/mct_pkg.sv]
// Package: types, codes and default sizes of the counting multiset table.
package mct_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int COUNT_BITS_DEF    = 16;
    localparam int KIND_W            = 2;
    localparam int KEY_W             = 32;
    localparam int KEY_COUNT_W       = 16;
    localparam int STATUS_W          = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_QUERY  = 2'd1,
        KIND_DELETE = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK     = 2'd0,
        STATUS_FULL   = 2'd1,
        STATUS_ABSENT = 2'd2,
        STATUS_SAT    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_LOOK,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic load;
        logic match;
        logic look;
        logic update;
    } mct_cmd_t;

    typedef struct packed {
        logic out_free;
    } mct_sts_t;

endpackage

[rtl/mct_if.sv]
// Valid/ready channel interfaces for operation requests and results.
interface mct_in_if
    import mct_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [KIND_W-1:0]       kind;
    logic signed [KEY_W-1:0] key;

    modport source (output valid, output kind, output key, input ready);
    modport sink   (input valid, input kind, input key, output ready);
endinterface

interface mct_out_if
    import mct_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [KEY_COUNT_W-1:0] key_count;
    logic [STATUS_W-1:0]    status;

    modport source (output valid, output key_count, output status, input ready);
    modport sink   (input valid, input key_count, input status, output ready);
endinterface

[rtl/mct_ctrl.sv]
// Controller: sequences load, key match, lookup and update for each transaction.
`include "assert_macros.svh"
module mct_ctrl
    import mct_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  mct_sts_t sts,
    output mct_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH:  state_next = ST_LOOK;
            ST_LOOK:   state_next = ST_UPDATE;
            ST_UPDATE:
            begin
                // hold until the result register can take the new result
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_MATCH:  cmd.match = 1'b1;
            ST_LOOK:   cmd.look = 1'b1;
            ST_UPDATE: cmd.update = sts.out_free;
            default:
            begin
                cmd      = '0;
                in_ready = 1'b0;
            end
        endcase
    end

    `ASSERT_PROP(a_update_returns_idle, clk, rst_n, cmd.update |=> state_reg == ST_IDLE)
    `ASSERT_NEVER(a_ready_only_idle, clk, rst_n, in_ready && state_reg != ST_IDLE)
    `ASSERT_PROP(a_load_goes_match, clk, rst_n, cmd.load |=> state_reg == ST_MATCH)

endmodule

[rtl/mct_dpath.sv]
// Datapath: key table, valid bits, count memory, update logic and result register.
`include "assert_macros.svh"
module mct_dpath
    import mct_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int COUNT_BITS    = COUNT_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  mct_cmd_t                cmd,
    output mct_sts_t                sts,
    input  logic [KIND_W-1:0]       in_kind,
    input  logic signed [KEY_W-1:0] in_key,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [KEY_COUNT_W-1:0]  out_key_count,
    output logic [STATUS_W-1:0]     out_status
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Lowest set bit of a vector; zero when none is set.
    function automatic logic [IDX_W-1:0] lowest(input logic [TABLE_ENTRIES-1:0] v);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

    logic [KIND_W-1:0]        kind_reg;
    logic [KEY_W-1:0]         key_reg;
    logic [KEY_W-1:0]         key_mem [TABLE_ENTRIES];
    logic [COUNT_BITS-1:0]    cnt_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [TABLE_ENTRIES-1:0] valid_next;
    logic [TABLE_ENTRIES-1:0] match_reg;
    logic [TABLE_ENTRIES-1:0] match_vec;
    logic                     hit_reg;
    logic [IDX_W-1:0]         hit_idx_reg;
    logic [IDX_W-1:0]         hit_idx;
    logic                     free_any_reg;
    logic [IDX_W-1:0]         free_idx_reg;
    logic [COUNT_BITS-1:0]    rd_cnt_reg;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [KEY_COUNT_W-1:0]   out_count_reg;
    logic [STATUS_W-1:0]      out_status_reg;

    // update results
    logic                     cnt_wr_en;
    logic [IDX_W-1:0]         cnt_wr_idx;
    logic [COUNT_BITS-1:0]    cnt_wr_data;
    logic                     key_wr_en;
    logic                     clr_valid;
    logic [COUNT_BITS-1:0]    res_count;
    status_t                  res_status;

    always_comb
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            match_vec[i] = valid_reg[i] && (key_mem[i] == key_reg);
        end
    end

    assign hit_idx = lowest(match_reg);

    always_comb
    begin
        cnt_wr_en   = 1'b0;
        cnt_wr_idx  = hit_idx_reg;
        cnt_wr_data = rd_cnt_reg;
        key_wr_en   = 1'b0;
        clr_valid   = 1'b0;
        res_count   = '0;
        res_status  = STATUS_OK;
        case (kind_reg)
            KIND_INSERT:
            begin
                if (hit_reg)
                begin
                    if (rd_cnt_reg == COUNT_MAX)
                    begin
                        res_status = STATUS_SAT;
                        res_count  = rd_cnt_reg;
                    end
                    else
                    begin
                        cnt_wr_en   = 1'b1;
                        cnt_wr_data = rd_cnt_reg + COUNT_BITS'(1);
                        res_count   = cnt_wr_data;
                    end
                end
                else if (free_any_reg)
                begin
                    // take the lowest free entry with a count of one
                    cnt_wr_en   = 1'b1;
                    cnt_wr_idx  = free_idx_reg;
                    cnt_wr_data = COUNT_BITS'(1);
                    key_wr_en   = 1'b1;
                    res_count   = COUNT_BITS'(1);
                end
                else
                begin
                    res_status = STATUS_FULL;
                end
            end
            KIND_DELETE:
            begin
                if (!hit_reg)
                begin
                    res_status = STATUS_ABSENT;
                end
                else if (rd_cnt_reg <= COUNT_BITS'(1))
                begin
                    clr_valid = 1'b1;
                end
                else
                begin
                    cnt_wr_en   = 1'b1;
                    cnt_wr_data = rd_cnt_reg - COUNT_BITS'(1);
                    res_count   = cnt_wr_data;
                end
            end
            default:
            begin
                // count query; the unused code behaves the same
                if (hit_reg)
                begin
                    res_count = rd_cnt_reg;
                end
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.update && key_wr_en)
        begin
            valid_next[free_idx_reg] = 1'b1;
        end
        if (cmd.update && clr_valid)
        begin
            valid_next[hit_idx_reg] = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.update)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= in_kind;
            key_reg  <= in_key;
        end
        if (cmd.match)
        begin
            match_reg <= match_vec;
        end
        if (cmd.look)
        begin
            hit_reg      <= |match_reg;
            hit_idx_reg  <= hit_idx;
            free_any_reg <= !(&valid_reg);
            free_idx_reg <= lowest(~valid_reg);
            rd_cnt_reg   <= cnt_mem[hit_idx];
        end
        if (cmd.update && cnt_wr_en)
        begin
            cnt_mem[cnt_wr_idx] <= cnt_wr_data;
        end
        if (cmd.update && key_wr_en)
        begin
            key_mem[free_idx_reg] <= key_reg;
        end
        if (cmd.update)
        begin
            out_count_reg  <= KEY_COUNT_W'(res_count);
            out_status_reg <= res_status;
        end
    end

    assign sts.out_free  = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_key_count = out_count_reg;
    assign out_status    = out_status_reg;

    `ASSERT_PROP(a_keys_unique, clk, rst_n, cmd.look |-> $onehot0(match_reg))
    `ASSERT_NEVER(a_new_key_free_slot, clk, rst_n, cmd.update && key_wr_en && valid_reg[free_idx_reg])
    `ASSERT_PROP(a_result_posted, clk, rst_n, cmd.update |=> out_valid_reg)

endmodule

[rtl/multiset_count_table.sv]
// Top level of the counting multiset table: controller plus datapath.
//
//  channel  | dir | payload                     | transfer
//  ---------+-----+-----------------------------+----------------------
//  in_ch    | in  | kind[1:0], key[31:0] signed | valid && ready
//  out_ch   | out | key_count[15:0], status[1:0]| valid && ready
//
// Each transaction passes through these steps in order: capture at acceptance, parallel key
// compare over all entries, hit/free encode with count memory read, update. The update
// loads the result register, which drives out_ch.
// The controller handles one transaction at a time; the next is accepted the
// cycle after the update, while the previous result may still wait in out_ch.
// A stalled out_ch holds the update until its result register frees up.
// Reset clears all valid bits at once, so the table is empty with no sweep.
module multiset_count_table
    import mct_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int COUNT_BITS    = COUNT_BITS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    mct_in_if.sink   in_ch,
    mct_out_if.source out_ch
);

    mct_cmd_t cmd;
    mct_sts_t sts;

    mct_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mct_dpath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .COUNT_BITS    (COUNT_BITS)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .in_kind       (in_ch.kind),
        .in_key        (in_ch.key),
        .out_valid     (out_ch.valid),
        .out_ready     (out_ch.ready),
        .out_key_count (out_ch.key_count),
        .out_status    (out_ch.status)
    );

endmodule
